// ----- rtl/tlpte_pkg.sv -----
// Shared constants, codes and memory request types of the two-level page table engine
`timescale 1ns / 1ps
package tlpte_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_POOL    = 16;

    localparam int DIR_IDX_W   = $clog2(DIR_ENTRIES);
    localparam int TAB_IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int TBL_NUM_W   = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int POOL_CNT_W  = $clog2(TABLE_POOL + 1);
    localparam int DIR_W       = 3 + TBL_NUM_W;
    localparam int TBL_ADDR_W  = TBL_NUM_W + TAB_IDX_W;
    localparam int TBL_DEPTH   = TABLE_POOL * TABLE_ENTRIES;

    localparam int ADDR_W      = 32;
    localparam int FLAGS_W     = 12;
    localparam int OFFSET_W    = 12;

    localparam int ENT_PRESENT_BIT  = 0;
    localparam int ENT_WRITABLE_BIT = 1;
    localparam int ENT_USER_BIT     = 2;

    typedef enum logic [1:0] {
        ACT_MAP       = 2'd0,
        ACT_UNMAP     = 2'd1,
        ACT_TRANSLATE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_POOL_EMPTY = 2'd1,
        STAT_DIR_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_TBL
    } state_t;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [DIR_IDX_W-1:0] addr;
        logic [DIR_W-1:0]     wdata;
    } dir_req_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [TBL_ADDR_W-1:0] addr;
        logic [ADDR_W-1:0]     wdata;
    } tbl_req_t;

endpackage

// ----- rtl/tlpte_dir_mem.sv -----
// Page directory memory, one write or read port, registered read data
`timescale 1ns / 1ps
module tlpte_dir_mem
(
    input  logic                           clk,
    input  tlpte_pkg::dir_req_t            req,
    output logic [tlpte_pkg::DIR_W-1:0]    rdata
);

    logic [tlpte_pkg::DIR_W-1:0] mem [tlpte_pkg::DIR_ENTRIES];
    logic [tlpte_pkg::DIR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tlpte_tbl_mem.sv -----
// Page table pool memory, one write or read port, registered read data
`timescale 1ns / 1ps
module tlpte_tbl_mem
(
    input  logic                            clk,
    input  tlpte_pkg::tbl_req_t             req,
    output logic [tlpte_pkg::ADDR_W-1:0]    rdata
);

    logic [tlpte_pkg::ADDR_W-1:0] mem [tlpte_pkg::TBL_DEPTH];
    logic [tlpte_pkg::ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tlpte_ctrl.sv -----
// Sequencer: clearing sweep, directory walk, table update or lookup, result register
`timescale 1ns / 1ps
module tlpte_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic                                cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [tlpte_pkg::ADDR_W-1:0]        virt_addr,
    input  logic [tlpte_pkg::ADDR_W-1:0]        phys_addr,
    input  logic [tlpte_pkg::FLAGS_W-1:0]       map_flags,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [tlpte_pkg::ADDR_W-1:0]        phys_out,
    output logic                                invalidate,
    output tlpte_pkg::dir_req_t                 dir_req,
    input  logic [tlpte_pkg::DIR_W-1:0]         dir_rdata,
    output tlpte_pkg::tbl_req_t                 tbl_req,
    input  logic [tlpte_pkg::ADDR_W-1:0]        tbl_rdata
);

    localparam int TOP_DIR_BIT = tlpte_pkg::ADDR_W - 1;
    localparam int LOW_DIR_BIT = tlpte_pkg::ADDR_W - tlpte_pkg::DIR_IDX_W;
    localparam int TOP_TAB_BIT = tlpte_pkg::OFFSET_W + tlpte_pkg::TAB_IDX_W - 1;

    tlpte_pkg::state_t state_reg, state_next;

    logic [tlpte_pkg::TBL_ADDR_W-1:0]   clr_cnt_reg;
    logic                               paging_reg;
    logic [tlpte_pkg::POOL_CNT_W-1:0]   nft_reg, nft_next;

    logic [1:0]                         act_reg;
    logic [tlpte_pkg::ADDR_W-1:0]       va_reg;
    logic [tlpte_pkg::ADDR_W-1:0]       pa_reg;
    logic [tlpte_pkg::FLAGS_W-1:0]      flags_reg;

    logic                               out_valid_reg, out_valid_next;
    logic [1:0]                         status_reg, status_next;
    logic [tlpte_pkg::ADDR_W-1:0]       phys_reg, phys_next;
    logic                               inval_reg, inval_next;

    logic                               accept;
    logic                               out_free;
    logic                               present;
    logic                               pool_empty;
    logic                               clr_last;
    logic                               res_load;
    logic                               nft_inc;
    logic [tlpte_pkg::DIR_W-1:0]        dir_new;
    logic [tlpte_pkg::TAB_IDX_W-1:0]    tab_idx;
    logic [tlpte_pkg::ADDR_W-1:0]       map_entry;

    assign out_free   = !out_valid_reg || !out_stall;
    assign present    = dir_rdata[tlpte_pkg::ENT_PRESENT_BIT];
    assign pool_empty = nft_reg >= tlpte_pkg::POOL_CNT_W'(tlpte_pkg::TABLE_POOL);
    assign clr_last   = clr_cnt_reg == tlpte_pkg::TBL_ADDR_W'(tlpte_pkg::TBL_DEPTH - 1);
    assign accept     = in_valid && !in_stall;
    assign tab_idx    = va_reg[TOP_TAB_BIT:tlpte_pkg::OFFSET_W];
    assign map_entry  = {pa_reg[tlpte_pkg::ADDR_W-1:tlpte_pkg::OFFSET_W],
                         flags_reg[tlpte_pkg::FLAGS_W-1:1], 1'b1};

    always_comb
    begin
        if (present)
        begin
            dir_new = dir_rdata;
            dir_new[tlpte_pkg::ENT_USER_BIT] = dir_rdata[tlpte_pkg::ENT_USER_BIT]
                                               | flags_reg[tlpte_pkg::ENT_USER_BIT];
        end
        else
        begin
            dir_new = {nft_reg[tlpte_pkg::TBL_NUM_W-1:0],
                       flags_reg[tlpte_pkg::ENT_USER_BIT], 1'b1, 1'b1};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlpte_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = tlpte_pkg::ST_IDLE;
                end
            end
            tlpte_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tlpte_pkg::ST_DIR;
                end
            end
            tlpte_pkg::ST_DIR:
            begin
                if (act_reg == tlpte_pkg::ACT_TRANSLATE && present)
                begin
                    state_next = tlpte_pkg::ST_TBL;
                end
                else if (out_free)
                begin
                    state_next = tlpte_pkg::ST_IDLE;
                end
            end
            tlpte_pkg::ST_TBL:
            begin
                if (out_free)
                begin
                    state_next = tlpte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlpte_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and memory requests
    always_comb
    begin
        in_stall    = 1'b1;
        dir_req     = '0;
        tbl_req     = '0;
        res_load    = 1'b0;
        nft_inc     = 1'b0;
        status_next = tlpte_pkg::STAT_OK;
        phys_next   = '0;
        inval_next  = 1'b0;
        case (state_reg)
            tlpte_pkg::ST_CLEAR:
            begin
                dir_req.we   = clr_cnt_reg[tlpte_pkg::TBL_ADDR_W-1:tlpte_pkg::DIR_IDX_W] == '0;
                dir_req.addr = clr_cnt_reg[tlpte_pkg::DIR_IDX_W-1:0];
                tbl_req.we   = 1'b1;
                tbl_req.addr = clr_cnt_reg;
            end
            tlpte_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                dir_req.re   = in_valid;
                dir_req.addr = virt_addr[TOP_DIR_BIT:LOW_DIR_BIT];
            end
            tlpte_pkg::ST_DIR:
            begin
                dir_req.addr = va_reg[TOP_DIR_BIT:LOW_DIR_BIT];
                dir_req.wdata = dir_new;
                tbl_req.addr = {dir_new[tlpte_pkg::DIR_W-1:3], tab_idx};
                case (act_reg)
                    tlpte_pkg::ACT_MAP:
                    begin
                        res_load = out_free;
                        if (present || !pool_empty)
                        begin
                            dir_req.we    = out_free;
                            tbl_req.we    = out_free;
                            tbl_req.wdata = map_entry;
                            nft_inc       = out_free && !present;
                            inval_next    = paging_reg;
                        end
                        else
                        begin
                            status_next = tlpte_pkg::STAT_POOL_EMPTY;
                        end
                    end
                    tlpte_pkg::ACT_UNMAP:
                    begin
                        res_load = out_free;
                        if (present)
                        begin
                            tbl_req.we = out_free;
                            inval_next = paging_reg;
                        end
                        else
                        begin
                            status_next = tlpte_pkg::STAT_DIR_ABSENT;
                        end
                    end
                    tlpte_pkg::ACT_TRANSLATE:
                    begin
                        tbl_req.re = present;
                        res_load   = out_free && !present;
                    end
                    default:
                    begin
                        res_load = out_free;
                    end
                endcase
            end
            tlpte_pkg::ST_TBL:
            begin
                res_load = out_free;
                if (tbl_rdata[tlpte_pkg::ENT_PRESENT_BIT])
                begin
                    phys_next = {tbl_rdata[tlpte_pkg::ADDR_W-1:tlpte_pkg::OFFSET_W],
                                 va_reg[tlpte_pkg::OFFSET_W-1:0]};
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign nft_next       = nft_inc ? tlpte_pkg::POOL_CNT_W'(nft_reg + 1'b1) : nft_reg;
    assign out_valid_next = res_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpte_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            paging_reg    <= 1'b0;
            nft_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nft_reg       <= nft_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == tlpte_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= tlpte_pkg::TBL_ADDR_W'(clr_cnt_reg + 1'b1);
            end
            if (cfg_write_en)
            begin
                paging_reg <= cfg_write_data;
            end
        end
    end

    // hold the transaction and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            va_reg    <= virt_addr;
            pa_reg    <= phys_addr;
            flags_reg <= map_flags;
        end
        if (res_load)
        begin
            status_reg <= status_next;
            phys_reg   <= phys_next;
            inval_reg  <= inval_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign phys_out   = phys_reg;
    assign invalidate = inval_reg;

    a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == tlpte_pkg::ST_DIR)
        else $error("accepted transaction did not start the directory walk");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nft_reg <= tlpte_pkg::POOL_CNT_W'(tlpte_pkg::TABLE_POOL))
        else $error("table pool count beyond pool size");

    a_pool_only_in_dir: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != tlpte_pkg::ST_DIR |=> $stable(nft_reg))
        else $error("table pool count moved outside the directory step");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past(state_reg) == tlpte_pkg::ST_DIR || $past(state_reg) == tlpte_pkg::ST_TBL)
        else $error("result raised without a walk");

    a_inval_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && inval_reg |-> status_reg == tlpte_pkg::STAT_OK && phys_reg == '0)
        else $error("invalidate with failing status or translated address");

endmodule

// ----- rtl/two_level_page_table_engine.sv -----
// Top level of the two-level page table engine
//
// channel   direction  handshake                 payload
// cfg       in         cfg_write_en              cfg_write_data (paging enabled)
// in        in         in_valid / in_stall       action, virt_addr, phys_addr, map_flags
// out       out        out_valid / out_stall     status, phys_out, invalidate
//
// Map, unmap, unused actions and translates whose directory entry is absent load the
// result register in ST_DIR after acceptance; a translate that finds its directory
// entry loads it in ST_TBL, after one table memory read more. A new transaction is
// accepted only in ST_IDLE, once the last one has loaded its result register.
// After reset a clearing sweep writes zeros over all TABLE_POOL * TABLE_ENTRIES
// (16384) table pool entries and the directory; in_stall stays high meanwhile.
// A stalled result holds in the output register; the next transaction is accepted
// meanwhile and waits at its final step until the register frees.
`timescale 1ns / 1ps
module two_level_page_table_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic                                cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [tlpte_pkg::ADDR_W-1:0]        virt_addr,
    input  logic [tlpte_pkg::ADDR_W-1:0]        phys_addr,
    input  logic [tlpte_pkg::FLAGS_W-1:0]       map_flags,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [tlpte_pkg::ADDR_W-1:0]        phys_out,
    output logic                                invalidate
);

    tlpte_pkg::dir_req_t                dir_req;
    tlpte_pkg::tbl_req_t                tbl_req;
    logic [tlpte_pkg::DIR_W-1:0]        dir_rdata;
    logic [tlpte_pkg::ADDR_W-1:0]       tbl_rdata;

    tlpte_dir_mem u_dir_mem
    (
        .clk   (clk),
        .req   (dir_req),
        .rdata (dir_rdata)
    );

    tlpte_tbl_mem u_tbl_mem
    (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    tlpte_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .virt_addr      (virt_addr),
        .phys_addr      (phys_addr),
        .map_flags      (map_flags),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .phys_out       (phys_out),
        .invalidate     (invalidate),
        .dir_req        (dir_req),
        .dir_rdata      (dir_rdata),
        .tbl_req        (tbl_req),
        .tbl_rdata      (tbl_rdata)
    );

endmodule

// ----- bench/tlpte_checker.sv -----
// Checker for the page table engine: predicts each walk and compares the result channel
`timescale 1ns / 1ps
module tlpte_checker
    import tlpte_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic                cfg_write_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          action,
    input  logic [ADDR_W-1:0]   virt_addr,
    input  logic [ADDR_W-1:0]   phys_addr,
    input  logic [FLAGS_W-1:0]  map_flags,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          status,
    input  logic [ADDR_W-1:0]   phys_out,
    input  logic                invalidate,
    output int                  mismatches,
    output int                  pending,
    output int                  checked
);

    typedef struct packed {
        logic                 present;
        logic                 writable;
        logic                 user;
        logic [TBL_NUM_W-1:0] table_num;
    } dir_entry_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] phys;
        logic              inval;
    } walk_result_t;

    dir_entry_t        page_dir [DIR_ENTRIES];
    logic [ADDR_W-1:0] pool_entry [TBL_DEPTH];
    int                tables_taken;
    logic              paging_on;
    walk_result_t      walk_results_q [$];

    initial
    begin
        for (int i = 0; i < DIR_ENTRIES; i++)
            page_dir[i] = '0;
        for (int i = 0; i < TBL_DEPTH; i++)
            pool_entry[i] = '0;
        tables_taken = 0;
    end

    function automatic walk_result_t walk_and_update(logic [1:0] act, logic [ADDR_W-1:0] va,
                                                     logic [ADDR_W-1:0] pa,
                                                     logic [FLAGS_W-1:0] flags);
        walk_result_t          r;
        dir_entry_t            d;
        logic [DIR_IDX_W-1:0]  di;
        logic [TBL_ADDR_W-1:0] slot;
        logic [ADDR_W-1:0]     e;
        r.status = STAT_OK;
        r.phys   = '0;
        r.inval  = 1'b0;
        di = va[31:22];
        d  = page_dir[di];
        case (act)
            ACT_MAP:
            begin
                if (!d.present && tables_taken >= TABLE_POOL)
                    r.status = STAT_POOL_EMPTY;
                else
                begin
                    if (!d.present)
                    begin
                        d.present   = 1'b1;
                        d.writable  = 1'b1;
                        d.user      = flags[ENT_USER_BIT];
                        d.table_num = tables_taken[TBL_NUM_W-1:0];
                        tables_taken++;
                    end
                    else
                        d.user = d.user | flags[ENT_USER_BIT];
                    page_dir[di] = d;
                    slot = {d.table_num, va[21:12]};
                    pool_entry[slot] = {pa[31:12], flags[11:1], 1'b1};
                    r.inval = paging_on;
                end
            end
            ACT_UNMAP:
            begin
                if (!d.present)
                    r.status = STAT_DIR_ABSENT;
                else
                begin
                    slot = {d.table_num, va[21:12]};
                    pool_entry[slot] = '0;
                    r.inval = paging_on;
                end
            end
            ACT_TRANSLATE:
            begin
                if (d.present)
                begin
                    slot = {d.table_num, va[21:12]};
                    e = pool_entry[slot];
                    if (e[ENT_PRESENT_BIT])
                        r.phys = {e[31:12], va[11:0]};
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        walk_result_t want;
        if (!rst_n)
        begin
            paging_on  = 1'b0;
            mismatches = 0;
            checked    = 0;
            walk_results_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
                paging_on = cfg_write_data;
            // compare before queueing so an early result cannot hide behind a new entry
            if (out_valid && !out_stall)
            begin
                checked++;
                if (walk_results_q.size() == 0)
                begin
                    $error("result arrived with no transaction outstanding");
                    mismatches++;
                end
                else
                begin
                    want = walk_results_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (phys_out !== want.phys)
                    begin
                        $error("phys_out: expected %h, actual %h", want.phys, phys_out);
                        mismatches++;
                    end
                    if (invalidate !== want.inval)
                    begin
                        $error("invalidate: expected %0d, actual %0d", want.inval, invalidate);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                walk_results_q.push_back(walk_and_update(action, virt_addr, phys_addr,
                                                         map_flags));
            pending <= walk_results_q.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the page table engine: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;
    import tlpte_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 440;
    localparam int         PHASES       = 4;
    localparam int         HOT_DIRS     = 24;
    localparam int         HOT_TABS     = 8;
    localparam int         DRAIN        = 8;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic                cfg_write_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          action;
    logic [ADDR_W-1:0]   virt_addr;
    logic [ADDR_W-1:0]   phys_addr;
    logic [FLAGS_W-1:0]  map_flags;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   phys_out;
    logic                invalidate;

    int                  mismatches;
    int                  pending;
    int                  checked;
    int                  sent;
    int                  directed;
    int                  stall_left;
    bit                  quiet;
    logic [9:0]          hot_dirs [HOT_DIRS];
    logic [9:0]          hot_tabs [HOT_TABS];
    logic [PHASES-1:0]   phase_paging;

    two_level_page_table_engine uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .virt_addr      (virt_addr),
        .phys_addr      (phys_addr),
        .map_flags      (map_flags),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .phys_out       (phys_out),
        .invalidate     (invalidate)
    );

    tlpte_checker walk_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .virt_addr      (virt_addr),
        .phys_addr      (phys_addr),
        .map_flags      (map_flags),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .phys_out       (phys_out),
        .invalidate     (invalidate),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int idle_len();
        if (quiet)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 2);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= idle_len();
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_item(input logic [1:0] act, input logic [ADDR_W-1:0] va,
                             input logic [ADDR_W-1:0] pa, input logic [FLAGS_W-1:0] flags);
        int gap;
        in_valid  <= 1'b1;
        action    <= act;
        virt_addr <= va;
        phys_addr <= pa;
        map_flags <= flags;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid, drain every outstanding walk, then let the engine return to idle
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_paging(input logic value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin
        logic [1:0]        act;
        logic [ADDR_W-1:0] va;
        int                pick;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= 1'b0;
        in_valid       <= 1'b0;
        action         <= ACT_MAP;
        virt_addr      <= '0;
        phys_addr      <= '0;
        map_flags      <= '0;
        out_stall      <= 1'b0;
        stall_left     <= 0;
        quiet          = 1'b0;
        sent           = 0;
        phase_paging   = 4'b0101;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_paging(1'b0);
        send_item(ACT_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
        send_item(ACT_UNMAP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_item(ACT_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        send_item(ACT_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000);
        send_item(ACT_MAP,       32'h0000_1000, 32'h1234_5FFF, 12'h000);
        send_item(ACT_TRANSLATE, 32'h0000_1ABC, 32'h0, 12'h000);
        send_item(ACT_UNMAP,     32'h0000_2000, 32'h0, 12'h000);
        send_item(ACT_UNMAP,     32'h0000_1000, 32'h0, 12'h000);
        send_item(ACT_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000);
        send_item(ACT_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'h004);
        send_item(ACT_TRANSLATE, 32'hFFFF_F000, 32'h0, 12'h000);
        send_item(ACT_UNUSED,    $urandom(), $urandom(), 12'hFFF);
        settle();
        write_paging(1'b1);
        send_item(ACT_MAP,       32'h0040_0000, 32'hABCD_E123, 12'h002);
        send_item(ACT_UNMAP,     32'h0040_0000, 32'h0, 12'h000);
        send_item(ACT_UNMAP,     32'h8000_0000, 32'h0, 12'h000);
        send_item(ACT_TRANSLATE, 32'h003F_FFFF, 32'h0, 12'h000);
        send_item(ACT_UNUSED,    32'h0000_0000, 32'h0, 12'h000);
        directed = sent;

        hot_dirs[0] = 10'd0;
        hot_dirs[1] = 10'd1023;
        hot_dirs[2] = 10'd1;
        for (int i = 3; i < HOT_DIRS; i++)
            hot_dirs[i] = 10'($urandom_range(0, 1023));
        hot_tabs[0] = 10'd0;
        hot_tabs[1] = 10'd1023;
        for (int i = 2; i < HOT_TABS; i++)
            hot_tabs[i] = 10'($urandom_range(0, 1023));

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_paging(phase_paging[p]);
            quiet = (p == 2);
            repeat (RANDOM_ITEMS / PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    act = ACT_MAP;
                else if (pick < 55)
                    act = ACT_UNMAP;
                else if (pick < 95)
                    act = ACT_TRANSLATE;
                else
                    act = ACT_UNUSED;
                va = $urandom();
                // keep most walks on a few directory and table slots so they revisit mappings
                if ($urandom_range(0, 4) != 0)
                begin
                    va[31:22] = hot_dirs[$urandom_range(0, HOT_DIRS - 1)];
                    va[21:12] = hot_tabs[$urandom_range(0, HOT_TABS - 1)];
                end
                send_item(act, va, $urandom(), 12'($urandom_range(0, 4095)));
            end
        end
        quiet = 1'b1;
        settle();

        $display("Run covered %0d transactions (%0d directed) and %0d compared results,",
                 sent, directed, checked);
        $display("with paging switched off and on across %0d random phases.", PHASES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
